// ----- hw/rtl/mmms_pkg.sv -----
// min/max/middle stack: request and response types, codes and control program
`default_nettype none

package mmms_pkg;

  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STEP_W  = 3;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_APPLY  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_POPCAP = 3'd2;
  localparam logic [STEP_W-1:0] STEP_TOP    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MID    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_DONE   = 3'd6;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [31:0]   popped_value;
    logic signed [31:0]   top_value;
    logic signed [31:0]   lowest_value;
    logic signed [31:0]   highest_value;
    logic signed [31:0]   middle_value;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;
  } rsp_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_MID,
    RD_IDX
  } rd_sel_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_REQ,
    COND_EMPTY,
    COND_SCAN_LAST,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    rd_sel_e           rd_sel;
    logic              ready;
    logic              capture;
    logic              apply;
    logic              ld_popped;
    logic              ld_top;
    logic              ld_mid;
    logic              scan;
    logic              emit;
    cond_e             cond;
    logic              hold;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // control store: next step is target when cond holds, else this step if hold, else the next
  function automatic ctrl_t ctrl_rom(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{rd_sel: RD_TOP, ready: 1'b0, capture: 1'b0, apply: 1'b0, ld_popped: 1'b0,
          ld_top: 1'b0, ld_mid: 1'b0, scan: 1'b0, emit: 1'b0, cond: COND_NEVER,
          hold: 1'b0, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        c.ready   = 1'b1;
        c.capture = 1'b1;
        c.cond    = COND_REQ;
        c.hold    = 1'b1;
        c.target  = STEP_APPLY;
      end
      STEP_APPLY: begin
        c.apply  = 1'b1;
        c.rd_sel = RD_TOP;
      end
      STEP_POPCAP: begin
        c.ld_popped = 1'b1;
        c.rd_sel    = RD_TOP;
        c.cond      = COND_EMPTY;
        c.target    = STEP_DONE;
      end
      STEP_TOP: begin
        c.ld_top = 1'b1;
        c.rd_sel = RD_MID;
      end
      STEP_MID: begin
        c.ld_mid = 1'b1;
        c.rd_sel = RD_IDX;
      end
      STEP_SCAN: begin
        c.scan   = 1'b1;
        c.rd_sel = RD_IDX;
        c.cond   = COND_SCAN_LAST;
        c.hold   = 1'b1;
        c.target = STEP_DONE;
      end
      STEP_DONE: begin
        c.emit   = 1'b1;
        c.cond   = COND_OUT_FREE;
        c.hold   = 1'b1;
        c.target = STEP_IDLE;
      end
      default: begin
        c.cond   = COND_NEVER;
        c.hold   = 1'b0;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/min_max_middle_stack_top.sv -----
// min/max/middle stack: microcoded top level with stack memory and scan datapath
//
// Bounded LIFO of signed 32-bit words. Each request pushes, pops or only queries, and
// gets one response with status, popped word, top, lowest, highest, the word at
// index count/2 from the bottom, the count and an empty flag. A request passes the
// apply, popped, top, middle and scan steps (only apply and popped when left empty):
// the lowest/highest scan reads the stack memory one entry a cycle, and top, middle
// and popped words each take one memory read. A new request is accepted while the
// previous response waits in the output register.
`default_nettype none

module min_max_middle_stack_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mmms_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mmms_pkg::rsp_t     out_rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [mmms_pkg::STEP_W-1:0] step_q, step_d;
  mmms_pkg::ctrl_t             ctrl;

  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cnt_m1, cnt_half;
  logic [1:0]         cmd_q;
  logic signed [31:0] val_q;
  logic [1:0]         status_q;
  logic signed [31:0] popped_q, top_q, low_q, high_q, mid_q;
  logic signed [31:0] rd_q;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic               in_acc, out_free, cond_hit, empty, full;
  logic               out_valid_q, out_valid_d;
  mmms_pkg::rsp_t     out_q;

  logic signed [31:0] mem_q [DEPTH];

  assign ctrl     = mmms_pkg::ctrl_rom(step_q);
  assign in_acc   = in_valid_i & ctrl.ready;
  assign out_free = ~out_valid_q | out_ready_i;
  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CW'(DEPTH));
  assign cnt_m1   = cnt_q - CW'(1);
  assign cnt_half = cnt_q >> 1;

  // sequencer
  always_comb begin
    case (ctrl.cond)
      mmms_pkg::COND_REQ:       cond_hit = in_acc;
      mmms_pkg::COND_EMPTY:     cond_hit = empty;
      mmms_pkg::COND_SCAN_LAST: cond_hit = (idx_q == cnt_q);
      mmms_pkg::COND_OUT_FREE:  cond_hit = out_free;
      default:                  cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      step_d = ctrl.target;
    end else if (ctrl.hold) begin
      step_d = step_q;
    end else begin
      step_d = step_q + mmms_pkg::STEP_W'(1);
    end
  end

  // memory read address
  always_comb begin
    case (ctrl.rd_sel)
      mmms_pkg::RD_TOP: rd_addr = cnt_m1[AW-1:0];
      mmms_pkg::RD_MID: rd_addr = cnt_half[AW-1:0];
      mmms_pkg::RD_IDX: rd_addr = idx_q[AW-1:0];
      default:          rd_addr = idx_q[AW-1:0];
    endcase
  end

  assign wr_en = ctrl.apply & (cmd_q == mmms_pkg::CMD_PUSH) & ~full;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[AW-1:0]] <= val_q;
    end
    rd_q <= mem_q[rd_addr];
  end

  // count and scan index
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.apply) begin
      if (wr_en) begin
        cnt_d = cnt_q + CW'(1);
      end else if ((cmd_q == mmms_pkg::CMD_POP) && !empty) begin
        cnt_d = cnt_m1;
      end
    end
    idx_d = idx_q;
    if (ctrl.ld_top) begin
      idx_d = '0;
    end else if (ctrl.rd_sel == mmms_pkg::RD_IDX) begin
      idx_d = idx_q + CW'(1);
    end
  end

  assign out_valid_d = (out_valid_q & ~out_ready_i) | (ctrl.emit & out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= mmms_pkg::STEP_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl.capture && in_acc) begin
      cmd_q <= in_req_i.command;
      val_q <= in_req_i.push_value;
    end
    if (ctrl.apply) begin
      case (cmd_q)
        mmms_pkg::CMD_PUSH: status_q <= full ? mmms_pkg::STATUS_OVERFLOW : mmms_pkg::STATUS_OK;
        mmms_pkg::CMD_POP:  status_q <= empty ? mmms_pkg::STATUS_UNDERFLOW : mmms_pkg::STATUS_OK;
        default:            status_q <= mmms_pkg::STATUS_OK;
      endcase
    end
    if (ctrl.ld_popped) begin
      popped_q <= ((cmd_q == mmms_pkg::CMD_POP) && (status_q == mmms_pkg::STATUS_OK))
                  ? rd_q : '0;
    end
    if (ctrl.ld_top) begin
      top_q  <= rd_q;
      low_q  <= rd_q;
      high_q <= rd_q;
    end
    if (ctrl.ld_mid) begin
      mid_q <= rd_q;
    end
    if (ctrl.scan) begin
      if (rd_q < low_q) begin
        low_q <= rd_q;
      end
      if (high_q < rd_q) begin
        high_q <= rd_q;
      end
    end
    if (ctrl.emit && out_free) begin
      out_q.status        <= status_q;
      out_q.popped_value  <= popped_q;
      out_q.top_value     <= empty ? '0 : top_q;
      out_q.lowest_value  <= empty ? '0 : low_q;
      out_q.highest_value <= empty ? '0 : high_q;
      out_q.middle_value  <= empty ? '0 : mid_q;
      out_q.entry_count   <= (mmms_pkg::COUNT_W)'(cnt_q);
      out_q.is_empty      <= empty;
    end
  end

  assign in_ready_o  = ctrl.ready;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench for the min/max/middle stack: directed and random requests checked against a predictor
module tb_top;

  localparam int unsigned DEPTH      = 16;
  localparam logic [1:0]  CMD_QUERY  = 2'd2;
  localparam logic [1:0]  CMD_SPARE  = 2'd3;
  localparam int          LONG_HOLD  = 400;
  localparam int          SETTLE     = 30;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready_o;
  mmms_pkg::req_t     in_req;
  logic               out_valid_o;
  logic               out_ready;
  mmms_pkg::rsp_t     out_rsp_o;

  logic signed [31:0] shadow_words [DEPTH];
  int                 shadow_count;
  mmms_pkg::rsp_t     rsp_due [$];
  int                 fail_count;
  int                 req_idle_pct;
  int                 rsp_stall_pct;
  bit                 long_hold_req;

  min_max_middle_stack_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[min_max_middle_stack_top] ERROR");
    $finish;
  end

  // applies one request to the shadow stack and returns the response it should give
  function automatic mmms_pkg::rsp_t stack_predict(input mmms_pkg::req_t r);
    mmms_pkg::rsp_t     e;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    int                 i;
    e = '0;
    lo = '0;
    hi = '0;
    case (r.command)
      mmms_pkg::CMD_PUSH: begin
        if (shadow_count >= DEPTH) begin
          e.status = mmms_pkg::STATUS_OVERFLOW;
        end else begin
          shadow_words[shadow_count] = r.push_value;
          shadow_count++;
        end
      end
      mmms_pkg::CMD_POP: begin
        if (shadow_count == 0) begin
          e.status = mmms_pkg::STATUS_UNDERFLOW;
        end else begin
          shadow_count--;
          e.popped_value = shadow_words[shadow_count];
        end
      end
      default: begin
        e.status = mmms_pkg::STATUS_OK;
      end
    endcase
    if (shadow_count != 0) begin
      e.top_value = shadow_words[shadow_count - 1];
      lo = shadow_words[shadow_count - 1];
      hi = shadow_words[shadow_count - 1];
      for (i = 0; i < shadow_count; i++) begin
        if (shadow_words[i] < lo) lo = shadow_words[i];
        if (shadow_words[i] > hi) hi = shadow_words[i];
      end
      e.lowest_value  = lo;
      e.highest_value = hi;
      e.middle_value  = shadow_words[shadow_count / 2];
    end
    e.entry_count = mmms_pkg::COUNT_W'(shadow_count);
    e.is_empty    = (shadow_count == 0);
    return e;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic mmms_pkg::req_t random_request(input int push_pct);
    mmms_pkg::req_t r;
    int             roll;
    roll = $urandom_range(99);
    r.push_value = pick_word();
    if (roll < push_pct) r.command = mmms_pkg::CMD_PUSH;
    else if (roll < 92) r.command = mmms_pkg::CMD_POP;
    else if (roll < 97) r.command = CMD_QUERY;
    else r.command = CMD_SPARE;
    return r;
  endfunction

  // called just after a rising edge; returns at the edge that takes the request
  task automatic send_request(input mmms_pkg::req_t r);
    while ($urandom_range(99) < req_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    rsp_due.push_back(stack_predict(r));
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] word);
    mmms_pkg::req_t r;
    r.command    = cmd;
    r.push_value = word;
    send_request(r);
  endtask

  // alternate runs that fill the stack with runs that drain it
  task automatic run_random(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_request(random_request(((k / 40) % 2) ? 30 : 65));
    end
  endtask

  task automatic test_directed();
    int i;
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    send_cmd(CMD_QUERY, 32'h0);
    send_cmd(mmms_pkg::CMD_POP, 32'hffff_ffff);
    send_cmd(CMD_SPARE, 32'h1234_5678);
    for (i = 0; i < DEPTH; i++) begin
      case (i)
        0: send_cmd(mmms_pkg::CMD_PUSH, 32'h8000_0000);
        1: send_cmd(mmms_pkg::CMD_PUSH, 32'h7fff_ffff);
        2: send_cmd(mmms_pkg::CMD_PUSH, 32'h0);
        3: send_cmd(mmms_pkg::CMD_PUSH, 32'hffff_ffff);
        4: send_cmd(mmms_pkg::CMD_PUSH, 32'haaaa_aaaa);
        5: send_cmd(mmms_pkg::CMD_PUSH, 32'h5555_5555);
        default: send_cmd(mmms_pkg::CMD_PUSH, $urandom);
      endcase
    end
    // push onto a full stack
    send_cmd(mmms_pkg::CMD_PUSH, 32'h0bad_0bad);
    send_cmd(CMD_QUERY, 32'h0);
    send_cmd(mmms_pkg::CMD_POP, 32'h0);
    send_cmd(mmms_pkg::CMD_POP, 32'h0);
  endtask

  task automatic test_no_idle();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    run_random(300);
  endtask

  task automatic test_sender_idle();
    req_idle_pct  = 81;
    rsp_stall_pct = 0;
    run_random(290);
  endtask

  task automatic test_receiver_stall();
    req_idle_pct  = 0;
    rsp_stall_pct = 81;
    run_random(290);
  endtask

  task automatic test_both_idle();
    req_idle_pct  = 26;
    rsp_stall_pct = 26;
    run_random(290);
  endtask

  task automatic test_backpressure();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    long_hold_req = 1'b1;
    run_random(50);
  endtask

  // receiver side, including the long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) begin
          out_ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    mmms_pkg::rsp_t e;
    if (rst_ni && out_valid_o && out_ready) begin
      if (rsp_due.size() == 0) begin
        $display("%0t response with none expected: got %h", $time, out_rsp_o);
        fail_count++;
      end else begin
        e = rsp_due.pop_front();
        compare_field("status", 32'(e.status), 32'(out_rsp_o.status));
        compare_field("popped_value", e.popped_value, out_rsp_o.popped_value);
        compare_field("top_value", e.top_value, out_rsp_o.top_value);
        compare_field("lowest_value", e.lowest_value, out_rsp_o.lowest_value);
        compare_field("highest_value", e.highest_value, out_rsp_o.highest_value);
        compare_field("middle_value", e.middle_value, out_rsp_o.middle_value);
        compare_field("entry_count", 32'(e.entry_count), 32'(out_rsp_o.entry_count));
        compare_field("is_empty", 32'(e.is_empty), 32'(out_rsp_o.is_empty));
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_req        = '0;
    shadow_count  = 0;
    fail_count    = 0;
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    long_hold_req = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    in_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[min_max_middle_stack_top] OK");
    end else begin
      $display("[min_max_middle_stack_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mmms_pkg.sv
hw/rtl/min_max_middle_stack_top.sv
verif/tb_top.sv
